// ----- hw/rtl/msseq_pkg.sv -----
// ----------------------------------------------------------------------------
// msseq_pkg
// Shared types, codes, microprogram and LFSR helper of the step sequencer.
// ----------------------------------------------------------------------------
package msseq_pkg;

  // Command codes carried in the input transfer
  typedef enum logic [2:0] {
    CMD_CLOCK  = 3'd0,
    CMD_RESET  = 3'd1,
    CMD_SAVE   = 3'd2,
    CMD_LOAD   = 3'd3,
    CMD_RAND   = 3'd4,
    CMD_MUTATE = 3'd5,
    CMD_CLEAR  = 3'd6,
    CMD_SAMPLE = 3'd7
  } cmd_e;

  // Configuration register indexes
  localparam logic [2:0] REG_STEP_COUNT    = 3'd0;
  localparam logic [2:0] REG_DENSITY       = 3'd1;
  localparam logic [2:0] REG_MUTATION_RATE = 3'd2;
  localparam logic [2:0] REG_RANGE_GAIN    = 3'd3;
  localparam logic [2:0] REG_NOTE_MODE     = 3'd4;

  localparam logic [31:0] LFSR_SEED = 32'h1234_5678;
  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

  // Datapath operation selected by the current control word
  typedef enum logic [3:0] {
    UOP_FETCH,
    UOP_CLK_ADV,
    UOP_CLK_TRIG,
    UOP_RESET,
    UOP_SAVE,
    UOP_LOAD,
    UOP_RAND,
    UOP_MUT,
    UOP_CLEAR,
    UOP_STEP_RD,
    UOP_LATCH,
    UOP_EMIT
  } uop_e;

  // Sequencing of the control word
  typedef enum logic [1:0] {
    BR_NEXT,
    BR_GOTO,
    BR_DISPATCH,
    BR_WAIT
  } br_e;

  localparam int UPC_W = 4;

  // Microprogram addresses
  localparam logic [UPC_W-1:0] UC_FETCH     = 4'd0;
  localparam logic [UPC_W-1:0] UC_CLK_ADV   = 4'd1;
  localparam logic [UPC_W-1:0] UC_CLK_TRIG  = 4'd2;
  localparam logic [UPC_W-1:0] UC_RESET     = 4'd3;
  localparam logic [UPC_W-1:0] UC_SAVE      = 4'd4;
  localparam logic [UPC_W-1:0] UC_LOAD      = 4'd5;
  localparam logic [UPC_W-1:0] UC_RAND      = 4'd6;
  localparam logic [UPC_W-1:0] UC_MUT       = 4'd7;
  localparam logic [UPC_W-1:0] UC_CLEAR     = 4'd8;
  localparam logic [UPC_W-1:0] UC_SMP_RD    = 4'd9;
  localparam logic [UPC_W-1:0] UC_SMP_LATCH = 4'd10;
  localparam logic [UPC_W-1:0] UC_OUT_RD    = 4'd11;
  localparam logic [UPC_W-1:0] UC_OUT       = 4'd12;

  typedef struct packed {
    uop_e             op;
    br_e              br;
    logic [UPC_W-1:0] tgt;
  } ucw_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic       accept;  // input transfer this cycle
    logic [2:0] cmd;     // command of that transfer
    logic       done;    // current control word has finished
  } sts_t;

  typedef struct packed {
    logic [31:0] state;
    logic [15:0] bits;
  } lfsr_draw_t;

  function automatic ucw_t ucode_word(input logic [UPC_W-1:0] addr);
    ucw_t w;
    w = '{op: UOP_FETCH, br: BR_GOTO, tgt: UC_FETCH};
    case (addr)
      UC_FETCH:     w = '{op: UOP_FETCH,    br: BR_DISPATCH, tgt: UC_FETCH};
      UC_CLK_ADV:   w = '{op: UOP_CLK_ADV,  br: BR_NEXT,     tgt: UC_FETCH};
      UC_CLK_TRIG:  w = '{op: UOP_CLK_TRIG, br: BR_GOTO,     tgt: UC_OUT_RD};
      UC_RESET:     w = '{op: UOP_RESET,    br: BR_GOTO,     tgt: UC_OUT_RD};
      UC_SAVE:      w = '{op: UOP_SAVE,     br: BR_WAIT,     tgt: UC_OUT_RD};
      UC_LOAD:      w = '{op: UOP_LOAD,     br: BR_WAIT,     tgt: UC_OUT_RD};
      UC_RAND:      w = '{op: UOP_RAND,     br: BR_WAIT,     tgt: UC_OUT_RD};
      UC_MUT:       w = '{op: UOP_MUT,      br: BR_WAIT,     tgt: UC_OUT_RD};
      UC_CLEAR:     w = '{op: UOP_CLEAR,    br: BR_GOTO,     tgt: UC_OUT_RD};
      UC_SMP_RD:    w = '{op: UOP_STEP_RD,  br: BR_NEXT,     tgt: UC_FETCH};
      UC_SMP_LATCH: w = '{op: UOP_LATCH,    br: BR_NEXT,     tgt: UC_FETCH};
      UC_OUT_RD:    w = '{op: UOP_STEP_RD,  br: BR_NEXT,     tgt: UC_FETCH};
      UC_OUT:       w = '{op: UOP_EMIT,     br: BR_WAIT,     tgt: UC_FETCH};
      default:      w = '{op: UOP_FETCH,    br: BR_GOTO,     tgt: UC_FETCH};
    endcase
    return w;
  endfunction

  function automatic logic [UPC_W-1:0] dispatch(input logic [2:0] cmd);
    logic [UPC_W-1:0] a;
    case (cmd_e'(cmd))
      CMD_CLOCK:  a = UC_CLK_ADV;
      CMD_RESET:  a = UC_RESET;
      CMD_SAVE:   a = UC_SAVE;
      CMD_LOAD:   a = UC_LOAD;
      CMD_RAND:   a = UC_RAND;
      CMD_MUTATE: a = UC_MUT;
      CMD_CLEAR:  a = UC_CLEAR;
      CMD_SAMPLE: a = UC_SMP_RD;
      default:    a = UC_FETCH;
    endcase
    return a;
  endfunction

  // Clock the Galois LFSR n times (n <= 16), low bit out, MSB-first result
  function automatic lfsr_draw_t lfsr_draw(input logic [31:0] s, input int unsigned n);
    lfsr_draw_t r;
    r.state = s;
    r.bits  = '0;
    for (int unsigned k = 0; k < 16; k++) begin
      if (k < n) begin
        r.bits  = {r.bits[14:0], r.state[0]};
        r.state = (r.state >> 1) ^ (r.state[0] ? LFSR_TAPS : 32'h0);
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/msseq_ram.sv -----
// ----------------------------------------------------------------------------
// msseq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msseq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/msseq_useq.sv -----
// ----------------------------------------------------------------------------
// msseq_useq
// Microprogram counter and control store; issues one control word a cycle.
// ----------------------------------------------------------------------------
module msseq_useq
  import msseq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  sts_t sts_i,
  output uop_e op_o
);

  logic [UPC_W-1:0] upc_q, upc_d;
  ucw_t             word;

  assign word = ucode_word(upc_q);
  assign op_o = word.op;

  always_comb begin
    upc_d = upc_q;
    case (word.br)
      BR_NEXT:     upc_d = upc_q + UPC_W'(1);
      BR_GOTO:     upc_d = word.tgt;
      BR_DISPATCH: if (sts_i.accept) upc_d = dispatch(sts_i.cmd);
      BR_WAIT:     if (sts_i.done) upc_d = word.tgt;
      default:     upc_d = UC_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UC_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ----- hw/rtl/msseq_dpath.sv -----
// ----------------------------------------------------------------------------
// msseq_dpath
// Datapath: step counter, sweep counter, LFSR, live and bank pattern RAMs,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module msseq_dpath
  import msseq_pkg::*;
#(
  parameter int STEPS     = 16,
  parameter int BANKS     = 16,
  parameter int NOTE_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  uop_e        op_i,
  output sts_t        sts_o,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [8:0]  cfg_wdata_i
);

  localparam int IW = $clog2(STEPS);
  localparam int CW = $clog2(STEPS + 1);
  localparam int BW = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int BD = BANKS * STEPS;
  localparam int AW = $clog2(BD);
  localparam int LW = NOTE_BITS + 1;

  // Configuration
  logic [4:0] step_count_q;
  logic [8:0] density_q, mutation_rate_q, range_gain_q;
  logic [1:0] note_mode_q;

  // Control and state
  logic [IW-1:0]        step_q;
  logic [CW-1:0]        cnt_q;
  logic [3:0]           slot_q;
  logic [31:0]          lfsr_q;
  logic [NOTE_BITS-1:0] held_q;
  logic                 trig_q, eop_q;
  logic [STEPS-1:0]     live_vld_q;
  logic [BANKS-1:0]     bank_vld_q;
  logic                 live_rvld_q;
  logic                 out_vld_q;
  logic [23:0]          out_data_q;
  logic                 out_last_q;

  // Memory ports
  logic          live_we, bank_we;
  logic [IW-1:0] live_waddr, live_raddr;
  logic [LW-1:0] live_wdata, live_rdata, live_rd;
  logic [AW-1:0] bank_waddr, bank_raddr;
  logic [LW-1:0] bank_rdata, bank_rd;

  logic          accept;
  logic [CW-1:0] cnt_m1, cnt_lim;
  logic [6:0]    slot7;
  logic [BW-1:0] bsel;
  logic          slot_ok, sweep_last, out_free;
  logic [12:0]   base_w;
  logic [7:0]    len8, step_inc8;
  logic          wrap;
  logic [IW-1:0] step_nxt;

  lfsr_draw_t    d_note, d_gate, d_dec, m_note, m_gate;
  logic          mut_hit;
  logic [LW-1:0] rand_word, mut_word;

  logic [8:0]           gain;
  logic [NOTE_BITS-1:0] note_sel;
  logic [24:0]          prod;
  logic [15:0]          note_out;
  logic [7:0]           step8;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (op_i == UOP_FETCH);
  assign out_free      = !out_vld_q || m_axis_tready;

  assign slot7   = {3'b000, slot_q};
  assign bsel    = slot7[BW-1:0];
  assign slot_ok = (slot7 < 7'(BANKS));
  assign base_w  = 13'(slot_q) * 13'(STEPS);
  assign cnt_m1  = cnt_q - CW'(1);

  // Save and load run their sweep one step further to drain the registered read
  assign cnt_lim    = (op_i == UOP_SAVE || op_i == UOP_LOAD) ? CW'(STEPS) : CW'(STEPS - 1);
  assign sweep_last = (cnt_q == cnt_lim);

  always_comb begin
    sts_o.accept = accept;
    sts_o.cmd    = s_axis_tdata[2:0];
    case (op_i)
      UOP_SAVE, UOP_LOAD: sts_o.done = !slot_ok || sweep_last;
      UOP_RAND, UOP_MUT:  sts_o.done = sweep_last;
      UOP_EMIT:           sts_o.done = out_free;
      default:            sts_o.done = 1'b1;
    endcase
  end

  // Pattern length clamped to 2..STEPS
  always_comb begin
    if (step_count_q < 5'd2) begin
      len8 = 8'd2;
    end else if (8'(step_count_q) > 8'(STEPS)) begin
      len8 = 8'(STEPS);
    end else begin
      len8 = 8'(step_count_q);
    end
  end
  assign step_inc8 = 8'(step_q) + 8'd1;
  assign wrap      = !(step_inc8 < len8);
  assign step_nxt  = wrap ? '0 : IW'(step_inc8);

  // Random redraws
  always_comb begin
    d_note  = lfsr_draw(lfsr_q, NOTE_BITS);
    d_gate  = lfsr_draw(d_note.state, 8);
    d_dec   = lfsr_draw(lfsr_q, 8);
    m_note  = lfsr_draw(d_dec.state, NOTE_BITS);
    m_gate  = lfsr_draw(m_note.state, 8);
    mut_hit = ({1'b0, d_dec.bits[7:0]} < mutation_rate_q);
    rand_word = {({1'b0, d_gate.bits[7:0]} < density_q), d_note.bits[NOTE_BITS-1:0]};
    mut_word  = {({1'b0, m_gate.bits[7:0]} < density_q), m_note.bits[NOTE_BITS-1:0]};
  end

  assign live_rd = live_rvld_q ? live_rdata : '0;
  assign bank_rd = bank_vld_q[bsel] ? bank_rdata : '0;

  // Memory port steering
  always_comb begin
    live_we    = 1'b0;
    live_waddr = cnt_q[IW-1:0];
    live_wdata = rand_word;
    live_raddr = step_q;
    bank_we    = 1'b0;
    bank_waddr = AW'(base_w + 13'(cnt_m1));
    bank_raddr = AW'(base_w + 13'(cnt_q));
    case (op_i)
      UOP_CLK_ADV: live_raddr = step_nxt;
      UOP_SAVE: begin
        live_raddr = cnt_q[IW-1:0];
        bank_we    = slot_ok && (cnt_q != '0);
      end
      UOP_LOAD: begin
        live_we    = slot_ok && (cnt_q != '0);
        live_waddr = cnt_m1[IW-1:0];
        live_wdata = bank_rd;
      end
      UOP_RAND: live_we = 1'b1;
      UOP_MUT: begin
        live_we    = mut_hit;
        live_wdata = mut_word;
      end
      default: live_raddr = step_q;
    endcase
  end

  msseq_ram #(.WIDTH(LW), .DEPTH(STEPS)) u_live_ram (
    .clk_i   (clk_i),
    .we_i    (live_we),
    .waddr_i (live_waddr),
    .wdata_i (live_wdata),
    .raddr_i (live_raddr),
    .rdata_o (live_rdata)
  );

  msseq_ram #(.WIDTH(LW), .DEPTH(BD)) u_bank_ram (
    .clk_i   (clk_i),
    .we_i    (bank_we),
    .waddr_i (bank_waddr),
    .wdata_i (live_rd),
    .raddr_i (bank_raddr),
    .rdata_o (bank_rdata)
  );

  // Result: note times clamped gain, saturated to 16 bits
  assign gain     = (range_gain_q > 9'd256) ? 9'd256 : range_gain_q;
  assign note_sel = (note_mode_q == 2'd0) ? live_rd[NOTE_BITS-1:0] : held_q;
  assign prod     = 25'(note_sel) * 25'(gain);
  assign note_out = (prod > 25'h00_FFFF) ? 16'hFFFF : prod[15:0];
  assign step8    = 8'(step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q    <= 5'd16;
      density_q       <= 9'd128;
      mutation_rate_q <= 9'd128;
      range_gain_q    <= 9'd32;
      note_mode_q     <= 2'd0;
      step_q          <= '0;
      cnt_q           <= '0;
      slot_q          <= '0;
      lfsr_q          <= LFSR_SEED;
      held_q          <= '0;
      trig_q          <= 1'b0;
      eop_q           <= 1'b0;
      live_vld_q      <= '0;
      bank_vld_q      <= '0;
      live_rvld_q     <= 1'b0;
      out_vld_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_STEP_COUNT:    step_count_q    <= cfg_wdata_i[4:0];
          REG_DENSITY:       density_q       <= cfg_wdata_i;
          REG_MUTATION_RATE: mutation_rate_q <= cfg_wdata_i;
          REG_RANGE_GAIN:    range_gain_q    <= cfg_wdata_i;
          REG_NOTE_MODE:     note_mode_q     <= cfg_wdata_i[1:0];
          default: ;
        endcase
      end

      live_rvld_q <= live_vld_q[live_raddr];
      if (live_we) begin
        live_vld_q[live_waddr] <= 1'b1;
      end
      if (bank_we) begin
        bank_vld_q[bsel] <= 1'b1;
      end

      // Load a new result or drop the one just taken
      if (op_i == UOP_EMIT && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end

      case (op_i)
        UOP_FETCH: begin
          if (accept) begin
            slot_q <= s_axis_tdata[6:3];
            trig_q <= 1'b0;
            eop_q  <= 1'b0;
            cnt_q  <= '0;
          end
        end
        UOP_CLK_ADV: begin
          step_q <= step_nxt;
          eop_q  <= wrap;
        end
        UOP_CLK_TRIG: begin
          trig_q <= live_rd[NOTE_BITS];
          if (live_rd[NOTE_BITS] && note_mode_q[1]) begin
            held_q <= live_rd[NOTE_BITS-1:0];
          end
        end
        UOP_RESET: step_q <= '0;
        UOP_SAVE, UOP_LOAD: begin
          cnt_q <= sts_o.done ? '0 : cnt_q + CW'(1);
        end
        UOP_RAND: begin
          lfsr_q <= d_gate.state;
          cnt_q  <= sts_o.done ? '0 : cnt_q + CW'(1);
        end
        UOP_MUT: begin
          lfsr_q <= mut_hit ? m_gate.state : d_dec.state;
          cnt_q  <= sts_o.done ? '0 : cnt_q + CW'(1);
        end
        UOP_CLEAR: live_vld_q <= '0;
        UOP_LATCH: held_q <= live_rd[NOTE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Result payload, loaded with the transfer slot
  always_ff @(posedge clk_i) begin
    if (op_i == UOP_EMIT && out_free) begin
      out_data_q <= {2'b00, note_out, trig_q, live_rd[NOTE_BITS], step8[3:0]};
      out_last_q <= eop_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ----- hw/rtl/mutating_step_sequencer.sv -----
// ----------------------------------------------------------------------------
// mutating_step_sequencer
// Gate-and-note step sequencer with snapshot banks and random mutation.
// ----------------------------------------------------------------------------
// One command comes in per input transfer and exactly one result goes out.
// A microprogram of thirteen control words steps a small datapath; the live
// pattern and the snapshot banks sit in RAMs with registered reads, so every
// pattern sweep walks the steps one per cycle. Control words after accept:
// clock advance, trigger, read, emit; reset or clear, then read, emit; sample
// read, latch, read, emit; randomize and mutate a sweep of the steps; save and
// load a sweep one step longer, ended at once for an out-of-range slot; each
// then read and emit. The next command is taken in the cycle after the result
// register is loaded, even while that result still waits on m_axis_tready; a
// new result waits only if the old one has not been taken. Bank contents and
// the live pattern read as zero after reset through per-bank and per-step valid
// bits, so there is no clearing pass. Configuration writes take effect on the
// next edge and should only be made while no command is in flight.
// ----------------------------------------------------------------------------
module mutating_step_sequencer
  import msseq_pkg::*;
#(
  parameter int STEPS     = 16,
  parameter int BANKS     = 16,
  parameter int NOTE_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command transfer
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [2:0] command, [6:3] bank_slot, [7] zero
  // Result transfer
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [3:0] current_step, [4] gate_level,
                                      // [5] trigger_pulse, [21:6] note_out, [23:22] zero
  output logic        m_axis_tlast,   // end_of_pattern
  // Register writes
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [8:0]  cfg_wdata_i
);

  uop_e op;
  sts_t sts;

  // Control store and microprogram counter
  msseq_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .op_o   (op)
  );

  // Step state, LFSR, pattern and bank RAMs, result register
  msseq_dpath #(
    .STEPS     (STEPS),
    .BANKS     (BANKS),
    .NOTE_BITS (NOTE_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .sts_o         (sts),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // An accepted command always leaves the fetch word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (op != UOP_FETCH))
    else $error("command accepted but sequencer stayed in fetch");

  // A loaded result returns the sequencer to fetch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == UOP_EMIT && sts.done) |=> (op == UOP_FETCH && m_axis_tvalid))
    else $error("result load did not return to fetch");

  // A wrap always lands on step zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[3:0] == 4'd0))
    else $error("end of pattern on a nonzero step");

  // A trigger only fires on a gated step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[5]) |-> m_axis_tdata[4])
    else $error("trigger on an ungated step");

endmodule
